### sv/rlelg_pkg.sv
// shared types, codes and defaults for the run length encoder with literal groups
package rlelg_pkg;

    localparam int SYMBOL_BITS_DEF  = 8;
    localparam int MAX_LITERALS_DEF = 32;
    localparam int MAX_RUN_DEF      = 255;
    localparam int COUNT_BITS       = 9;

    typedef enum logic [1:0] {
        KIND_RUN     = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_LITERAL = 2'd2
    } kind_t;

    typedef struct packed {
        logic ext;
        logic load;
        logic push;
        logic move_run;
        logic clear_held;
        logic emit_hdr;
        logic emit_lit;
        logic emit_run;
        logic last;
        logic done;
    } cmd_t;

    typedef struct packed {
        logic in_eos;
        logic ext_ok;
        logic held_zero;
        logic held_one;
        logic fill_zero;
        logic full_after_push;
        logic lit_last;
        logic out_free;
    } stat_t;

endpackage

### sv/rlelg_if.sv
// symbol and code channel interfaces
interface rlelg_in_if #(
    parameter int SYMBOL_BITS = rlelg_pkg::SYMBOL_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   end_of_stream;

    modport source (output valid, input ready, output symbol, output end_of_stream);
    modport sink   (input valid, output ready, input symbol, input end_of_stream);
endinterface

interface rlelg_out_if #(
    parameter int SYMBOL_BITS = rlelg_pkg::SYMBOL_BITS_DEF
);
    logic                                     valid;
    logic                                     ready;
    rlelg_pkg::kind_t                         kind;
    logic signed [rlelg_pkg::COUNT_BITS-1:0]  count;
    logic [SYMBOL_BITS-1:0]                   value;
    logic                                     stream_done;
    logic                                     last_of_step;

    modport source (output valid, input ready, output kind, output count, output value,
                    output stream_done, output last_of_step);
    modport sink   (input valid, output ready, input kind, input count, input value,
                    input stream_done, input last_of_step);
endinterface

### sv/rlelg_dp.sv
// datapath: held run, pending run, literal store and output register
module rlelg_dp #(
    parameter int SYMBOL_BITS  = rlelg_pkg::SYMBOL_BITS_DEF,
    parameter int MAX_LITERALS = rlelg_pkg::MAX_LITERALS_DEF,
    parameter int MAX_RUN      = rlelg_pkg::MAX_RUN_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [SYMBOL_BITS-1:0]                  symbol,
    input  logic                                    end_of_stream,
    input  rlelg_pkg::cmd_t                         cmd,
    output rlelg_pkg::stat_t                        stat,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output rlelg_pkg::kind_t                        kind,
    output logic signed [rlelg_pkg::COUNT_BITS-1:0] count,
    output logic [SYMBOL_BITS-1:0]                  value,
    output logic                                    stream_done,
    output logic                                    last_of_step
);

    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int FW = $clog2(MAX_LITERALS + 1);
    localparam int AW = (MAX_LITERALS > 1) ? $clog2(MAX_LITERALS) : 1;
    localparam int NB = rlelg_pkg::COUNT_BITS;

    logic [SYMBOL_BITS-1:0] held_sym_reg;
    logic [CW-1:0]          held_cnt_reg;
    logic [CW-1:0]          held_cnt_next;
    logic [SYMBOL_BITS-1:0] prun_sym_reg;
    logic [CW-1:0]          prun_cnt_reg;
    logic [31:0]            prun_wide;
    logic [FW-1:0]          fill_reg;
    logic [AW-1:0]          idx_reg;
    logic [SYMBOL_BITS-1:0] mem [MAX_LITERALS];
    logic [SYMBOL_BITS-1:0] rd_data_reg;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   out_valid_reg;
    rlelg_pkg::kind_t       kind_reg;
    logic signed [NB-1:0]   count_reg;
    logic [SYMBOL_BITS-1:0] value_reg;
    logic                   done_reg;
    logic                   last_reg;
    logic                   emit;

    always_comb
    begin
        stat.in_eos          = end_of_stream;
        stat.ext_ok          = (held_cnt_reg != '0) && (symbol == held_sym_reg)
                               && (held_cnt_reg != CW'(MAX_RUN));
        stat.held_zero       = (held_cnt_reg == '0);
        stat.held_one        = (held_cnt_reg == CW'(1));
        stat.fill_zero       = (fill_reg == '0);
        stat.full_after_push = ((fill_reg + FW'(1)) == FW'(MAX_LITERALS));
        stat.lit_last        = ((FW'(idx_reg) + FW'(1)) == fill_reg);
        stat.out_free        = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        held_cnt_next = held_cnt_reg;
        if (cmd.ext)
        begin
            held_cnt_next = held_cnt_reg + CW'(1);
        end
        else if (cmd.load)
        begin
            held_cnt_next = CW'(1);
        end
        else if (cmd.clear_held)
        begin
            held_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_sym_reg <= '0;
            held_cnt_reg <= '0;
            fill_reg     <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            held_cnt_reg <= held_cnt_next;
            if (cmd.load)
            begin
                held_sym_reg <= symbol;
            end
            if (cmd.push)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            else if (cmd.emit_lit && stat.lit_last)
            begin
                fill_reg <= '0;
            end
            if (cmd.emit_hdr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.emit_lit && !stat.lit_last)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.move_run)
        begin
            prun_sym_reg <= held_sym_reg;
            prun_cnt_reg <= held_cnt_reg;
        end
    end

    // literal store
    assign rd_en   = cmd.emit_hdr || (cmd.emit_lit && !stat.lit_last);
    assign rd_addr = cmd.emit_hdr ? '0 : idx_reg + AW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[fill_reg[AW-1:0]] <= held_sym_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // output register
    assign emit      = cmd.emit_hdr || cmd.emit_lit || cmd.emit_run;
    assign prun_wide = 32'(prun_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            last_reg <= cmd.last;
            done_reg <= cmd.done;
            if (cmd.emit_hdr)
            begin
                kind_reg  <= rlelg_pkg::KIND_HEADER;
                count_reg <= NB'(0) - NB'(fill_reg);
                value_reg <= '0;
            end
            else if (cmd.emit_lit)
            begin
                kind_reg  <= rlelg_pkg::KIND_LITERAL;
                count_reg <= '0;
                value_reg <= rd_data_reg;
            end
            else
            begin
                kind_reg  <= rlelg_pkg::KIND_RUN;
                count_reg <= prun_wide[NB-1:0];
                value_reg <= prun_sym_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign count        = count_reg;
    assign value        = value_reg;
    assign stream_done  = done_reg;
    assign last_of_step = last_reg;

`ifndef SYNTH
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (fill_reg < FW'(MAX_LITERALS)))
        else $error("literal store overflow");

    a_lit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_lit |-> (fill_reg != '0))
        else $error("literal emitted from empty group");
`endif

endmodule

### sv/rlelg_ctrl.sv
// controller: sequences run closing, literal flushes and end of stream
module rlelg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rlelg_pkg::stat_t  stat,
    output rlelg_pkg::cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HDR   = 5'b00010,
        S_LIT   = 5'b00100,
        S_RUN   = 5'b01000,
        S_CLOSE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   eos_reg;
    logic   eos_next;
    logic   closed_reg;
    logic   closed_next;
    logic   run_pend_reg;
    logic   run_pend_next;
    logic   tail;

    // end of stream close still to come
    assign tail     = eos_reg && !closed_reg;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        eos_next      = eos_reg;
        closed_next   = closed_reg;
        run_pend_next = run_pend_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    eos_next      = stat.in_eos;
                    closed_next   = 1'b0;
                    run_pend_next = 1'b0;
                    if (stat.ext_ok)
                    begin
                        cmd.ext    = 1'b1;
                        state_next = stat.in_eos ? S_CLOSE : S_IDLE;
                    end
                    else if (stat.held_zero)
                    begin
                        cmd.load   = 1'b1;
                        state_next = stat.in_eos ? S_CLOSE : S_IDLE;
                    end
                    else if (stat.held_one)
                    begin
                        cmd.push = 1'b1;
                        cmd.load = 1'b1;
                        if (stat.full_after_push)
                        begin
                            state_next = S_HDR;
                        end
                        else
                        begin
                            state_next = stat.in_eos ? S_CLOSE : S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.move_run  = 1'b1;
                        cmd.load      = 1'b1;
                        run_pend_next = 1'b1;
                        state_next    = stat.fill_zero ? S_RUN : S_HDR;
                    end
                end
            end
            S_HDR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_hdr = 1'b1;
                    state_next   = S_LIT;
                end
            end
            S_LIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_lit = 1'b1;
                    if (stat.lit_last)
                    begin
                        cmd.last = !run_pend_reg && !tail;
                        cmd.done = !run_pend_reg && !tail && eos_reg;
                        if (run_pend_reg)
                        begin
                            state_next = S_RUN;
                        end
                        else
                        begin
                            state_next = tail ? S_CLOSE : S_IDLE;
                        end
                    end
                end
            end
            S_RUN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_run  = 1'b1;
                    cmd.last      = !tail;
                    cmd.done      = !tail && eos_reg;
                    run_pend_next = 1'b0;
                    state_next    = tail ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE:
            begin
                closed_next    = 1'b1;
                cmd.clear_held = 1'b1;
                if (stat.held_one)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_HDR;
                end
                else
                begin
                    cmd.move_run  = 1'b1;
                    run_pend_next = 1'b1;
                    state_next    = stat.fill_zero ? S_RUN : S_HDR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            eos_reg      <= 1'b0;
            closed_reg   <= 1'b0;
            run_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            eos_reg      <= eos_next;
            closed_reg   <= closed_next;
            run_pend_reg <= run_pend_next;
        end
    end

`ifndef SYNTH
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_hdr || cmd.emit_lit || cmd.emit_run) |-> stat.out_free)
        else $error("beat produced into a full output register");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |-> cmd.last)
        else $error("stream end flagged on a beat that is not the last");

    a_run_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> run_pend_reg)
        else $error("run emission without a pending run");
`endif

endmodule

### sv/run_length_encoder_literal_groups_top.sv
// top level of the run length encoder with literal groups
//
//   channel   role   beat contents
//   symbols   sink   symbol, end_of_stream
//   codes     source kind, count, value, stream_done, last_of_step
//
// a symbol that extends or starts a run is taken while idle; the next can follow at once
// closing a run of two or more sends the header and pending literals, if any, then the run beat
// a literal group flush sends one beat per cycle from the literal store while the output register is free, header first
// an end marker adds a close state before its final beats
// reset clears the held run and the literal count; the store needs no clearing
// the output register lets a finished beat wait while the next symbol is taken in idle
module run_length_encoder_literal_groups_top #(
    parameter int SYMBOL_BITS  = rlelg_pkg::SYMBOL_BITS_DEF,
    parameter int MAX_LITERALS = rlelg_pkg::MAX_LITERALS_DEF,
    parameter int MAX_RUN      = rlelg_pkg::MAX_RUN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rlelg_in_if.sink     symbols,
    rlelg_out_if.source  codes
);

    rlelg_pkg::cmd_t  cmd;
    rlelg_pkg::stat_t stat;

    rlelg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (symbols.valid),
        .in_ready (symbols.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rlelg_dp #(
        .SYMBOL_BITS  (SYMBOL_BITS),
        .MAX_LITERALS (MAX_LITERALS),
        .MAX_RUN      (MAX_RUN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .symbol        (symbols.symbol),
        .end_of_stream (symbols.end_of_stream),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (codes.valid),
        .out_ready     (codes.ready),
        .kind          (codes.kind),
        .count         (codes.count),
        .value         (codes.value),
        .stream_done   (codes.stream_done),
        .last_of_step  (codes.last_of_step)
    );

endmodule

### bench/tb_run_length_encoder_literal_groups_top.sv
// testbench for the run length encoder with literal groups: directed and random symbol streams
`timescale 1ns / 1ps

module tb_run_length_encoder_literal_groups_top;

    localparam int SYM_W       = rlelg_pkg::SYMBOL_BITS_DEF;
    localparam int LIT_MAX     = rlelg_pkg::MAX_LITERALS_DEF;
    localparam int RUN_MAX     = rlelg_pkg::MAX_RUN_DEF;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        rlelg_pkg::kind_t       kind;
        logic signed [8:0]      count;
        logic [SYM_W-1:0]       value;
        logic                   stream_done;
        logic                   last_of_step;
    } code_t;

    logic clk;
    logic rst_n;

    rlelg_in_if  symbols();
    rlelg_out_if codes();

    run_length_encoder_literal_groups_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (symbols),
        .codes   (codes)
    );

    // encoder state as predicted
    logic [SYM_W-1:0] run_symbol;
    int               run_length;
    logic [SYM_W-1:0] literal_buf [LIT_MAX];
    int               literal_count;

    code_t step_codes [$];
    code_t pending_codes [$];

    int src_idle_pct;
    int snk_stall_pct;
    int errors;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n                 = 1'b0;
        symbols.valid         = 1'b0;
        symbols.symbol        = '0;
        symbols.end_of_stream = 1'b0;
        codes.ready           = 1'b0;
    end

    function automatic void add_code(rlelg_pkg::kind_t k, int cnt, logic [SYM_W-1:0] v);
        code_t c;
        c.kind         = k;
        c.count        = 9'(cnt);
        c.value        = v;
        c.stream_done  = 1'b0;
        c.last_of_step = 1'b0;
        step_codes     = {step_codes, c};
    endfunction

    function automatic void flush_group();
        if (literal_count == 0)
            return;
        add_code(rlelg_pkg::KIND_HEADER, -literal_count, '0);
        for (int i = 0; i < literal_count; i++)
            add_code(rlelg_pkg::KIND_LITERAL, 0, literal_buf[i]);
        literal_count = 0;
    endfunction

    function automatic void close_current_run();
        if (run_length == 0)
            return;
        if (run_length >= 2)
        begin
            flush_group();
            add_code(rlelg_pkg::KIND_RUN, run_length, run_symbol);
        end
        else
        begin
            if (literal_count < LIT_MAX)
                literal_buf[literal_count++] = run_symbol;
            if (literal_count >= LIT_MAX)
                flush_group();
        end
        run_length = 0;
    endfunction

    function automatic void encode_symbol(logic [SYM_W-1:0] sym, logic eos);
        step_codes.delete();
        if (run_length != 0 && sym == run_symbol && run_length < RUN_MAX)
            run_length++;
        else
        begin
            close_current_run();
            run_symbol = sym;
            run_length = 1;
        end
        if (eos)
        begin
            close_current_run();
            flush_group();
        end
        if (step_codes.size() > 0)
        begin
            step_codes[step_codes.size()-1].last_of_step = 1'b1;
            step_codes[step_codes.size()-1].stream_done  = eos;
        end
        pending_codes = {pending_codes, step_codes};
    endfunction

    // prediction on each input beat, then comparison of each output beat
    always @(posedge clk)
    begin
        code_t got;
        code_t want;
        if (rst_n)
        begin
            if (symbols.valid && symbols.ready)
                encode_symbol(symbols.symbol, symbols.end_of_stream);
            if (codes.valid && codes.ready)
            begin
                got.kind         = codes.kind;
                got.count        = codes.count;
                got.value        = codes.value;
                got.stream_done  = codes.stream_done;
                got.last_of_step = codes.last_of_step;
                if (pending_codes.size() == 0)
                begin
                    $display("%0t unexpected beat: kind %0d count %0d value %0d done %0b last %0b",
                             $time, got.kind, got.count, got.value, got.stream_done,
                             got.last_of_step);
                    errors++;
                end
                else
                begin
                    want = pending_codes.pop_front();
                    if (got.kind !== want.kind || got.count !== want.count ||
                        got.value !== want.value || got.stream_done !== want.stream_done ||
                        got.last_of_step !== want.last_of_step)
                    begin
                        $display("%0t mismatch: expected kind %0d count %0d value %0d done %0b last %0b",
                                 $time, want.kind, want.count, want.value, want.stream_done,
                                 want.last_of_step);
                        $display("%0t           actual   kind %0d count %0d value %0d done %0b last %0b",
                                 $time, got.kind, got.count, got.value, got.stream_done,
                                 got.last_of_step);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        codes.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (symbols.valid && symbols.ready) || (codes.valid && codes.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic eos);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            symbols.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        symbols.valid         <= 1'b1;
        symbols.symbol        <= sym;
        symbols.end_of_stream <= eos;
        @(posedge clk);
        while (!symbols.ready)
            @(posedge clk);
    endtask

    task automatic drain_codes();
        symbols.valid <= 1'b0;
        @(posedge clk);
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // single symbols, short runs, mixes and field extremes
    task automatic test_basic_streams();
        set_idling(0, 0);
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hff, 1'b1);
        send_symbol(8'haa, 1'b0);
        send_symbol(8'haa, 1'b1);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h7f, 1'b0);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'hff, 1'b0);
        send_symbol(8'hff, 1'b0);
        send_symbol(8'h00, 1'b1);
        send_symbol(8'h3c, 1'b0);
        send_symbol(8'h3c, 1'b0);
        send_symbol(8'hc3, 1'b1);
        drain_codes();
    endtask

    // literal group reaches its limit and flushes on its own
    task automatic test_literal_group_full();
        set_idling(0, 36);
        for (int i = 0; i < LIT_MAX + 3; i++)
            send_symbol(SYM_W'(i * 37 + 5), i == LIT_MAX + 2);
        drain_codes();
    endtask

    // random streams of runs and literals, ending with an end marker
    task automatic test_random_streams(input int src_pct, input int snk_pct, input int beats);
        int               sent;
        int               len;
        logic [SYM_W-1:0] sym;
        logic             eos;
        set_idling(src_pct, snk_pct);
        sent = 0;
        while (sent < beats)
        begin
            if ($urandom_range(99) < 80)
            begin
                len = ($urandom_range(2) == 0) ? $urandom_range(6, 2) : 1;
                sym = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0)
                                               : SYM_W'($urandom_range(255));
                eos = ($urandom_range(9) == 0);
                for (int i = 0; i < len; i++)
                    send_symbol(sym, eos && i == len - 1);
            end
            else
            begin
                len = 1;
                send_symbol(SYM_W'($urandom), $urandom_range(19) == 0);
            end
            sent += len;
        end
        send_symbol(SYM_W'($urandom), 1'b1);
        drain_codes();
    endtask

    initial
    begin
        errors        = 0;
        quiet_cycles  = 0;
        run_symbol    = '0;
        run_length    = 0;
        literal_count = 0;
        set_idling(0, 0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_streams();
        test_literal_group_full();
        test_random_streams(0, 0, 12);
        test_random_streams(82, 0, 12);
        test_random_streams(0, 82, 12);
        test_random_streams(36, 36, 12);

        if (pending_codes.size() != 0)
        begin
            $display("%0t %0d expected beats never arrived", $time, pending_codes.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
